FILE: src/dlpt_pkg.sv
package dlpt_pkg;

    // input item modes
    localparam logic [1:0] MODE_LINE_BYTE = 2'd0;
    localparam logic [1:0] MODE_HOST_BYTE = 2'd1;
    localparam logic [1:0] MODE_TX_SLOT   = 2'd2;
    localparam logic [1:0] MODE_CLOSED    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_TX   = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CLOSED = 2'd1;
    localparam logic [1:0] ST_INTR   = 2'd2;
    localparam logic [1:0] ST_ERR    = 2'd3;

    // framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_INTR   = 8'h03;

    localparam logic [3:0] STOP_LEN         = 4'd7;
    localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd4;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_RECV  = 3'd1,
        PH_CK1   = 3'd2,
        PH_CK2   = 3'd3,
        PH_ACKP  = 3'd4,
        PH_AWAIT = 3'd5,
        PH_SEND  = 3'd6,
        PH_WACK  = 3'd7
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic       eof;
        logic [1:0] status;
    } result_t;

    // fixed stop frame "$S05#b8"
    function automatic logic [7:0] stop_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = CH_DOLLAR;
            4'd1:    v = 8'h53;
            4'd2:    v = 8'h30;
            4'd3:    v = 8'h35;
            4'd4:    v = CH_HASH;
            4'd5:    v = 8'h62;
            4'd6:    v = 8'h38;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

FILE: src/dlpt_reply_mem.sv
module dlpt_reply_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-through so the prefetched byte is never stale
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/dlpt_ctrl.sv
module dlpt_ctrl
    import dlpt_pkg::*;
#(
    parameter int FRAME_MAX = 256,
    parameter int AW        = 8,
    parameter int IW        = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic [1:0]    mode,
    input  logic [7:0]    byte_value,
    input  logic          is_final,
    input  logic [3:0]    max_attempts,
    input  logic [7:0]    rd_data,
    output result_t       res,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic [AW-1:0] rd_addr
);

    phase_t        phase_reg,    phase_next;
    logic [IW-1:0] rx_count_reg, rx_count_next;
    logic [IW-1:0] reply_len_reg, reply_len_next;
    logic [IW-1:0] send_idx_reg, send_idx_next;
    logic [3:0]    attempt_reg,  attempt_next;
    logic          stop_reg,     stop_next;

    logic [3:0]    lim;
    logic          attempts_done;
    logic          rx_overflow;
    logic          reply_full;
    logic [IW-1:0] send_len;
    logic [IW-1:0] send_inc;
    logic          send_last;
    logic [7:0]    send_byte;

    assign lim           = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
    assign attempts_done = ({1'b0, attempt_reg} + 5'd1) >= {1'b0, lim};
    assign rx_overflow   = ({1'b0, rx_count_reg} + (IW+1)'(3)) >= (IW+1)'(FRAME_MAX);
    assign reply_full    = reply_len_reg >= IW'(FRAME_MAX);
    assign send_len      = stop_reg ? IW'(STOP_LEN) : reply_len_reg;
    assign send_inc      = send_idx_reg + IW'(1);
    assign send_last     = send_inc >= send_len;
    assign send_byte     = stop_reg ? stop_byte(send_idx_reg[3:0]) : rd_data;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        rx_count_next  = rx_count_reg;
        reply_len_next = reply_len_reg;
        send_idx_next  = send_idx_reg;
        attempt_next   = attempt_reg;
        stop_next      = stop_reg;
        if (advance)
        begin
            unique case (mode)
                MODE_CLOSED:
                begin
                    phase_next = PH_HUNT;
                end
                MODE_HOST_BYTE:
                begin
                    if (phase_reg != PH_AWAIT || reply_full)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        reply_len_next = reply_len_reg + IW'(1);
                        if (is_final)
                        begin
                            stop_next     = 1'b0;
                            send_idx_next = '0;
                            attempt_next  = 4'd0;
                            phase_next    = PH_SEND;
                        end
                    end
                end
                MODE_TX_SLOT:
                begin
                    if (phase_reg == PH_ACKP)
                    begin
                        reply_len_next = '0;
                        phase_next     = PH_AWAIT;
                    end
                    else if (phase_reg == PH_SEND)
                    begin
                        send_idx_next = send_inc;
                        if (send_last)
                        begin
                            phase_next = PH_WACK;
                        end
                    end
                end
                default:
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (byte_value == CH_INTR)
                            begin
                                stop_next     = 1'b1;
                                send_idx_next = '0;
                                attempt_next  = 4'd0;
                                phase_next    = PH_SEND;
                            end
                            else if (byte_value == CH_DOLLAR)
                            begin
                                rx_count_next = IW'(1);
                                phase_next    = PH_RECV;
                            end
                        end
                        PH_RECV:
                        begin
                            if (rx_overflow)
                            begin
                                phase_next = PH_HUNT;
                            end
                            else
                            begin
                                rx_count_next = rx_count_reg + IW'(1);
                                if (byte_value == CH_HASH)
                                begin
                                    phase_next = PH_CK1;
                                end
                            end
                        end
                        PH_CK1:
                        begin
                            rx_count_next = rx_count_reg + IW'(1);
                            phase_next    = PH_CK2;
                        end
                        PH_CK2:
                        begin
                            rx_count_next = rx_count_reg + IW'(1);
                            phase_next    = PH_ACKP;
                        end
                        PH_WACK:
                        begin
                            if (byte_value == CH_PLUS || attempts_done)
                            begin
                                phase_next = PH_HUNT;
                            end
                            else
                            begin
                                attempt_next  = attempt_reg + 4'd1;
                                send_idx_next = '0;
                                phase_next    = PH_SEND;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        res        = '0;
        mem_we     = 1'b0;
        mem_waddr  = reply_len_reg[AW-1:0];
        mem_wdata  = byte_value;
        unique case (mode)
            MODE_CLOSED:
            begin
                res.valid  = 1'b1;
                res.kind   = KIND_STAT;
                res.status = ST_CLOSED;
            end
            MODE_HOST_BYTE:
            begin
                if (phase_reg != PH_AWAIT || reply_full)
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_STAT;
                    res.status = ST_ERR;
                end
                else
                begin
                    mem_we = advance;
                end
            end
            MODE_TX_SLOT:
            begin
                if (phase_reg == PH_ACKP)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_TX;
                    res.data  = CH_PLUS;
                    res.eof   = 1'b1;
                end
                else if (phase_reg == PH_SEND)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_TX;
                    res.data  = send_byte;
                    res.eof   = send_last;
                end
            end
            default:
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (byte_value == CH_INTR)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_STAT;
                            res.status = ST_INTR;
                        end
                        else if (byte_value == CH_DOLLAR)
                        begin
                            res.valid = 1'b1;
                            res.kind  = KIND_RX;
                            res.data  = byte_value;
                        end
                    end
                    PH_RECV:
                    begin
                        res.valid = 1'b1;
                        if (rx_overflow)
                        begin
                            res.kind   = KIND_STAT;
                            res.status = ST_ERR;
                        end
                        else
                        begin
                            res.kind = KIND_RX;
                            res.data = byte_value;
                        end
                    end
                    PH_CK1, PH_CK2:
                    begin
                        res.valid = 1'b1;
                        res.kind  = KIND_RX;
                        res.data  = byte_value;
                        res.eof   = (phase_reg == PH_CK2);
                    end
                    PH_WACK:
                    begin
                        if (byte_value == CH_PLUS)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_STAT;
                            res.status = ST_OK;
                        end
                        else if (attempts_done)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_STAT;
                            res.status = ST_ERR;
                        end
                    end
                    default:
                    begin
                        res.valid = 1'b0;
                    end
                endcase
            end
        endcase
    end

    // prefetch the byte at the upcoming send index
    assign rd_addr = send_idx_next[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            rx_count_reg  <= '0;
            reply_len_reg <= '0;
            send_idx_reg  <= '0;
            attempt_reg   <= 4'd0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rx_count_reg  <= rx_count_next;
            reply_len_reg <= reply_len_next;
            send_idx_reg  <= send_idx_next;
            attempt_reg   <= attempt_next;
            stop_reg      <= stop_next;
        end
    end

endmodule

FILE: src/debug_link_packet_transport.sv
// Debugger packet framing for a serial line. Each input transfer is a line
// byte, a host reply byte, a free transmit slot or a line-closed notice; each
// gives at most one result transfer (a frame byte for the host, a byte for
// the line, or a status event). One item is taken per clock while the result
// side keeps taking results. An accepted item is held in the input register
// while a single pass of the phase logic fills the result register as the
// item moves on; a stall on the result side holds it in the input register.
// Throughput is one item per cycle whenever the result side keeps taking
// results. Host reply bytes are held in a FRAME_MAX deep byte store; the
// byte for the next transmit slot is prefetched from it so that the send
// path stays a single pass. The store needs no clearing after reset.
module debug_link_packet_transport
    import dlpt_pkg::*;
#(
    parameter int FRAME_MAX = 256
) (
    input  logic       clk,
    input  logic       rst_n,

    // configuration: max_attempts
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,

    // input items
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] byte_value,
    input  logic       is_final,

    // result items
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] byte_out,
    output logic       end_of_frame,
    output logic [1:0] status
);

    localparam int AW = $clog2(FRAME_MAX);
    localparam int IW = $clog2(FRAME_MAX + 1);

    // configuration register
    logic [3:0] max_attempts_reg;

    // input register
    logic       in_valid_reg;
    logic [1:0] mode_reg;
    logic [7:0] byte_reg;
    logic       final_reg;

    // result register
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_out_reg;
    logic       eof_reg;
    logic [1:0] status_reg;

    logic          advance;
    result_t       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // the held item moves on when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= MAX_ATTEMPTS_RST;
        end
        else if (cfg_valid)
        begin
            max_attempts_reg <= cfg_data;
        end
    end

    // input register: valid is control, payload loads on every transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg  <= mode;
            byte_reg  <= byte_value;
            final_reg <= is_final;
        end
    end

    dlpt_ctrl #(
        .FRAME_MAX (FRAME_MAX),
        .AW        (AW),
        .IW        (IW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .mode         (mode_reg),
        .byte_value   (byte_reg),
        .is_final     (final_reg),
        .max_attempts (max_attempts_reg),
        .rd_data      (rd_data),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .rd_addr      (rd_addr)
    );

    dlpt_reply_mem #(
        .DEPTH (FRAME_MAX),
        .AW    (AW)
    ) u_reply_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // result register: items without a result just leave the slot empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res.valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg     <= res.kind;
            byte_out_reg <= res.data;
            eof_reg      <= res.eof;
            status_reg   <= res.status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign byte_out     = byte_out_reg;
    assign end_of_frame = eof_reg;
    assign status       = status_reg;

endmodule

FILE: tb/sv/tb.sv
module tb;
    import dlpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_MAX     = 256;
    localparam int QUIET_LIMIT   = 3000;  // cycles with no transfer on any channel
    localparam int PHASE_ITEMS   = 10;    // minimum number of random items queued per register setting
    localparam int SETTLE_CYCLES = 4;     // input and result register drain plus margin
    localparam int REPORT_MAX    = 10;

    // fixed stop frame, first character in the top byte
    localparam logic [55:0] STOP_TEXT = "$S05#b8";

    typedef struct {
        logic [1:0] mode;
        logic [7:0] val;
        logic       fin;
        bit         hold;   // sender waits for every predicted result before this one
    } link_item_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       eof;
        logic [1:0] status;
    } link_event_t;

    // receiver stall styles
    typedef enum int {
        RX_STEADY,
        RX_PATTERN,
        RX_RANDOM
    } rx_style_t;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data     = 4'd0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [1:0] mode         = MODE_LINE_BYTE;
    logic [7:0] byte_value   = 8'h00;
    logic       is_final     = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       end_of_frame;
    logic [1:0] status;

    // items waiting for the sender and results waiting for the line/host side
    link_item_t  serial_items[$];
    link_event_t link_events_due[$];

    // predicted block state
    phase_t      link_phase;
    int          rx_count;
    logic [7:0]  reply_mem [FRAME_MAX];
    int          reply_len;
    int          tx_idx;
    int          tries;
    bit          stop_flag;
    logic [3:0]  attempt_limit;

    // stimulus side bookkeeping
    int          gen_limit = 4;     // attempt limit the generator plans exchanges for
    bit          hold_next = 1'b0;
    int          items_queued = 0;

    int          bad_events = 0;
    int          quiet_cycles = 0;

    // sender burst/gap state
    int          burst_left = 0;
    int          gap_left = 0;
    link_item_t  next_item;
    link_event_t fresh_event;

    // receiver stall state
    rx_style_t   stall_style = RX_STEADY;
    int          stall_span = 0;
    logic [7:0]  stall_bits = 8'h01;
    link_event_t due_event;

    debug_link_packet_transport dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .byte_value   (byte_value),
        .is_final     (is_final),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .byte_out     (byte_out),
        .end_of_frame (end_of_frame),
        .status       (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // link model
    // ------------------------------------------------------------------

    function automatic void reset_link();
        link_phase    = PH_HUNT;
        rx_count      = 0;
        reply_len     = 0;
        tx_idx        = 0;
        tries         = 0;
        stop_flag     = 1'b0;
        attempt_limit = MAX_ATTEMPTS_RST;
    endfunction

    function automatic void begin_send(input bit stop);
        stop_flag  = stop;
        tx_idx     = 0;
        tries      = 0;
        link_phase = PH_SEND;
    endfunction

    // advance the link by one accepted item; returns 1 when a result is due
    function automatic bit advance_link(input logic [1:0] m, input logic [7:0] b,
                                        input logic fin, output link_event_t ev);
        int         len;
        int         lim;
        logic [7:0] v;
        ev = '{KIND_STAT, 8'h00, 1'b0, ST_OK};

        // line closed wins from any phase
        if (m == MODE_CLOSED)
        begin
            link_phase = PH_HUNT;
            ev.status  = ST_CLOSED;
            return 1'b1;
        end

        // host reply bytes only belong in the await-reply phase, and only fit the store
        if (m == MODE_HOST_BYTE)
        begin
            if (link_phase != PH_AWAIT || reply_len >= FRAME_MAX)
            begin
                link_phase = PH_HUNT;
                ev.status  = ST_ERR;
                return 1'b1;
            end
            reply_mem[reply_len] = b;
            reply_len++;
            if (fin)
                begin_send(1'b0);
            return 1'b0;
        end

        // free transmit slot: acknowledge first, then reply or stop frame bytes
        if (m == MODE_TX_SLOT)
        begin
            if (link_phase == PH_ACKP)
            begin
                reply_len  = 0;
                link_phase = PH_AWAIT;
                ev = '{KIND_TX, CH_PLUS, 1'b1, ST_OK};
                return 1'b1;
            end
            if (link_phase == PH_SEND)
            begin
                len = stop_flag ? int'(STOP_LEN) : reply_len;
                v   = 8'h00;
                if (stop_flag)
                begin
                    if (tx_idx < int'(STOP_LEN))
                        v = STOP_TEXT[55 - 8 * tx_idx -: 8];
                end
                else if (tx_idx < FRAME_MAX)
                begin
                    v = reply_mem[tx_idx];
                end
                tx_idx++;
                ev = '{KIND_TX, v, (tx_idx >= len), ST_OK};
                if (tx_idx >= len)
                    link_phase = PH_WACK;
                return 1'b1;
            end
            return 1'b0;  // nothing to send
        end

        // line byte
        case (link_phase)
            PH_HUNT:
            begin
                if (b == CH_INTR)
                begin
                    begin_send(1'b1);
                    ev.status = ST_INTR;
                    return 1'b1;
                end
                if (b == CH_DOLLAR)
                begin
                    rx_count   = 1;
                    link_phase = PH_RECV;
                    ev = '{KIND_RX, b, 1'b0, ST_OK};
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_RECV:
            begin
                // frame would not leave room for the checksum digits
                if (rx_count + 3 >= FRAME_MAX)
                begin
                    link_phase = PH_HUNT;
                    ev.status  = ST_ERR;
                    return 1'b1;
                end
                rx_count++;
                if (b == CH_HASH)
                    link_phase = PH_CK1;
                ev = '{KIND_RX, b, 1'b0, ST_OK};
                return 1'b1;
            end
            PH_CK1:
            begin
                rx_count++;
                link_phase = PH_CK2;
                ev = '{KIND_RX, b, 1'b0, ST_OK};
                return 1'b1;
            end
            PH_CK2:
            begin
                rx_count++;
                link_phase = PH_ACKP;
                ev = '{KIND_RX, b, 1'b1, ST_OK};
                return 1'b1;
            end
            PH_WACK:
            begin
                if (b == CH_PLUS)
                begin
                    link_phase = PH_HUNT;
                    ev.status  = ST_OK;
                    return 1'b1;
                end
                // a zero limit behaves as a single transmission
                lim = (attempt_limit == 4'd0) ? 1 : int'(attempt_limit);
                if (tries + 1 >= lim)
                begin
                    link_phase = PH_HUNT;
                    ev.status  = ST_ERR;
                    return 1'b1;
                end
                tries++;
                tx_idx     = 0;
                link_phase = PH_SEND;
                return 1'b0;
            end
            default:
                return 1'b0;  // line bytes dropped while acking, awaiting or sending
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    task automatic put(input logic [1:0] m, input logic [7:0] b, input logic f);
        serial_items.push_back('{m, b, f, hold_next});
        hold_next = 1'b0;
        items_queued++;
    endtask

    // occasional stray item of any mode: misplaced host bytes, closes, odd line bytes
    task automatic maybe_stray();
        if ($urandom_range(0, 9) == 0)
            put(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // one debugger exchange with random content, sometimes the stop frame instead
    task automatic queue_exchange();
        int         n;
        int         len;
        int         lim;
        int         shots;
        logic [7:0] b;
        hold_next = hold_next || ($urandom_range(0, 7) == 0);
        lim = (gen_limit == 0) ? 1 : gen_limit;

        // a close brings the block back to hunting whatever came before
        if ($urandom_range(0, 3) == 0)
            put(MODE_CLOSED, 8'($urandom), 1'($urandom_range(0, 1)));

        if ($urandom_range(0, 4) == 0)
        begin
            put(MODE_LINE_BYTE, CH_INTR, 1'($urandom_range(0, 1)));
            len = int'(STOP_LEN);
        end
        else
        begin
            // line noise skipped while hunting
            repeat ($urandom_range(0, 2))
            begin
                b = 8'($urandom);
                if (b == CH_DOLLAR || b == CH_INTR)
                    b = b ^ 8'h40;
                put(MODE_LINE_BYTE, b, 1'($urandom_range(0, 1)));
            end
            put(MODE_LINE_BYTE, CH_DOLLAR, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 10))
            begin
                b = 8'($urandom);
                if (b == CH_HASH)
                    b = b ^ 8'h80;
                put(MODE_LINE_BYTE, b, 1'($urandom_range(0, 1)));
            end
            put(MODE_LINE_BYTE, CH_HASH, 1'($urandom_range(0, 1)));
            put(MODE_LINE_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
            put(MODE_LINE_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
            maybe_stray();
            put(MODE_TX_SLOT, 8'($urandom), 1'($urandom_range(0, 1)));
            len = $urandom_range(1, 8);
            for (n = 0; n < len; n++)
                put(MODE_HOST_BYTE, 8'($urandom), (n == len - 1));
        end

        // transmissions, each but the last answered by a nak; the last mostly by an ack
        shots = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(1, (lim < 3) ? lim : 3);
        for (n = 0; n < shots; n++)
        begin
            repeat (len)
                put(MODE_TX_SLOT, 8'($urandom), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
                put(MODE_TX_SLOT, 8'($urandom), 1'b0);  // slot with nothing to send
            maybe_stray();
            b = 8'($urandom);
            if (b == CH_PLUS)
                b = 8'h2D;
            if (n == shots - 1 && $urandom_range(0, 2) != 0)
                b = CH_PLUS;
            put(MODE_LINE_BYTE, b, 1'($urandom_range(0, 1)));
        end
    endtask

    // frame that overflows on its last payload byte, then a reply one byte too long
    task automatic queue_overflows();
        logic [7:0] b;
        put(MODE_CLOSED, 8'h00, 1'b0);
        put(MODE_LINE_BYTE, CH_DOLLAR, 1'b0);
        repeat (FRAME_MAX - 3)
        begin
            b = 8'($urandom);
            if (b == CH_HASH)
                b = b ^ 8'h80;
            put(MODE_LINE_BYTE, b, 1'($urandom_range(0, 1)));
        end
        put(MODE_LINE_BYTE, CH_DOLLAR, 1'b0);
        put(MODE_LINE_BYTE, CH_HASH, 1'b0);
        put(MODE_LINE_BYTE, 8'h30, 1'b0);
        put(MODE_LINE_BYTE, 8'h30, 1'b0);
        put(MODE_TX_SLOT, 8'h00, 1'b0);
        repeat (FRAME_MAX)
            put(MODE_HOST_BYTE, 8'($urandom), 1'b0);
        put(MODE_HOST_BYTE, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // wait until every item is through and every result has come, then let the pipe drain
    task automatic settle();
        while (serial_items.size() != 0 || in_valid || link_events_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attempt_limit(input logic [3:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        // register transfer happened at this edge; block is idle so the model can follow now
        cfg_valid     <= 1'b0;
        attempt_limit  = v;
        gen_limit      = int'(v);
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length, random gaps, optional hold-off
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // an input transfer moves the model on
            if (in_valid && in_ready)
            begin
                if (advance_link(mode, byte_value, is_final, fresh_event))
                    link_events_due.push_back(fresh_event);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (serial_items.size() == 0 ||
                         (serial_items[0].hold && link_events_due.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_item   = serial_items.pop_front();
                    mode       <= next_item.mode;
                    byte_value <= next_item.val;
                    is_final   <= next_item.fin;
                    in_valid   <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // a quarter of the bursts run straight into the next one
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: checks each result transfer, stalls on its own pattern
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (link_events_due.size() == 0)
            begin
                bad_events++;
                if (bad_events <= REPORT_MAX)
                    $display("unexpected result: kind %0d byte %02h eof %0b status %0d",
                             kind, byte_out, end_of_frame, status);
            end
            else
            begin
                due_event = link_events_due.pop_front();
                if (kind !== due_event.kind || byte_out !== due_event.data ||
                    end_of_frame !== due_event.eof || status !== due_event.status)
                begin
                    bad_events++;
                    if (bad_events <= REPORT_MAX)
                        $display("mismatch: kind %0d/%0d byte %02h/%02h eof %0b/%0b status %0d/%0d",
                                 due_event.kind, kind, due_event.data, byte_out,
                                 due_event.eof, end_of_frame, due_event.status, status);
                end
            end
        end

        // stall style changes when its span runs out
        if (stall_span == 0)
        begin
            stall_style = rx_style_t'($urandom_range(0, 2));
            stall_span  = $urandom_range(24, 160);
            stall_bits  = 8'($urandom) | 8'h01;  // at least one ready bit set in the rotating pattern
        end
        else
        begin
            stall_span--;
        end
        stall_bits = {stall_bits[6:0], stall_bits[7]};
        case (stall_style)
            RX_STEADY:  out_ready <= 1'b1;
            RX_PATTERN: out_ready <= stall_bits[0];
            default:    out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // watchdog: nothing transferred on any channel for too long
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        logic [3:0] limit_plan [5];
        int         mark;
        int         i;
        limit_plan = '{4'd15, 4'd1, 4'd0, 4'd9, 4'd4};
        limit_plan[3] = 4'($urandom_range(2, 14));
        reset_link();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: error and idle corners, one full exchange, interrupt with stop frame
        put(MODE_CLOSED, 8'h00, 1'b0);
        put(MODE_HOST_BYTE, 8'hFF, 1'b1);        // host byte while hunting
        put(MODE_TX_SLOT, 8'hFF, 1'b1);          // slot with nothing to send
        put(MODE_LINE_BYTE, 8'h41, 1'b1);        // skipped while hunting
        put(MODE_LINE_BYTE, CH_DOLLAR, 1'b0);
        put(MODE_LINE_BYTE, 8'h00, 1'b0);
        put(MODE_LINE_BYTE, 8'hFF, 1'b0);
        put(MODE_LINE_BYTE, CH_HASH, 1'b0);
        put(MODE_LINE_BYTE, 8'h33, 1'b0);
        put(MODE_LINE_BYTE, 8'h37, 1'b0);        // last checksum digit
        put(MODE_LINE_BYTE, 8'h7A, 1'b0);        // dropped while ack is pending
        put(MODE_TX_SLOT, 8'h00, 1'b0);          // '+' goes out
        put(MODE_HOST_BYTE, 8'hA5, 1'b0);
        put(MODE_HOST_BYTE, 8'h5A, 1'b1);
        put(MODE_TX_SLOT, 8'h00, 1'b0);
        put(MODE_TX_SLOT, 8'h00, 1'b0);
        put(MODE_TX_SLOT, 8'h00, 1'b0);          // waiting for ack, nothing to send
        put(MODE_LINE_BYTE, CH_PLUS, 1'b0);
        put(MODE_LINE_BYTE, CH_INTR, 1'b0);
        repeat (STOP_LEN)
            put(MODE_TX_SLOT, 8'h00, 1'b0);
        put(MODE_LINE_BYTE, CH_PLUS, 1'b0);
        settle();

        // random exchanges under several attempt limits, extremes included
        hold_next = 1'b1;
        for (i = 0; i < 5; i++)
        begin
            write_attempt_limit(limit_plan[i]);
            mark = items_queued;
            while (items_queued - mark < PHASE_ITEMS)
                queue_exchange();
            if (i == 1)
                queue_overflows();
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_events == 0 && link_events_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
